@@ sv/blt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types and constants of the branch label table.
// ----------------------------------------------------------------------------
package blt_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_W     = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DEPTH_W   = 10;
    localparam int BCI_W     = 16;
    localparam int LIT_W     = 16;
    localparam int SLOT_W    = 8;
    localparam int OP_W      = 2;
    localparam int OCC_W     = 2;
    localparam int STATUS_W  = 3;

    localparam logic [OP_W-1:0] OP_RECORD  = 2'd0;
    localparam logic [OP_W-1:0] OP_RESOLVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [OCC_W-1:0] OCC_DEF    = 2'd0;
    localparam logic [OCC_W-1:0] OCC_SIMPLE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MULTI_DEF = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDEFINED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [DEPTH_W-1:0] depth;
        logic [BCI_W-1:0]   bci;
        logic               defined;
        logic               has_lit;
        logic [LIT_W-1:0]   literal;
    } t_hit;

    typedef struct packed {
        logic               look;
        logic               insert;
        logic               set_def;
        logic               set_lit;
        logic [CNT_W-1:0]   count;
        logic [KEY_W-1:0]   key;
        logic [DEPTH_W-1:0] depth;
        logic [BCI_W-1:0]   bci;
        logic               defined;
        logic [LIT_W-1:0]   literal;
    } t_cell_cmd;

endpackage
`default_nettype wire

@@ sv/blt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// blt_cell
// One table entry: key compare, hit flag, and a link of the hit data chain.
// ----------------------------------------------------------------------------
module blt_cell
    import blt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_index,
    input  wire t_cell_cmd        i_cmd,
    input  wire t_hit             i_chain,
    output t_hit                  o_chain,
    output logic                  o_hit
);

    logic [KEY_W-1:0]   r_key;
    logic [DEPTH_W-1:0] r_depth;
    logic [BCI_W-1:0]   r_bci;
    logic               r_defined;
    logic               r_has_lit;
    logic [LIT_W-1:0]   r_literal;
    logic               r_hit;

    logic w_valid;
    logic w_slot;
    t_hit w_own;

    assign w_valid = CNT_W'(i_index) < i_cmd.count;
    assign w_slot  = CNT_W'(i_index) == i_cmd.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.look) begin
            r_hit <= w_valid && (r_key == i_cmd.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && w_slot) begin
            r_key     <= i_cmd.key;
            r_depth   <= i_cmd.depth;
            r_bci     <= i_cmd.bci;
            r_defined <= i_cmd.defined;
            r_has_lit <= i_cmd.set_lit;
            r_literal <= i_cmd.set_lit ? i_cmd.literal : '0;
        end else if (r_hit && !i_cmd.insert) begin
            if (i_cmd.set_def) begin
                r_bci     <= i_cmd.bci;
                r_defined <= 1'b1;
            end
            if (i_cmd.set_lit) begin
                r_has_lit <= 1'b1;
                r_literal <= i_cmd.literal;
            end
        end
    end

    always_comb begin
        w_own         = '0;
        w_own.hit     = 1'b1;
        w_own.depth   = r_depth;
        w_own.bci     = r_bci;
        w_own.defined = r_defined;
        w_own.has_lit = r_has_lit;
        w_own.literal = r_literal;
    end

    assign o_chain = r_hit ? (i_chain | w_own) : i_chain;
    assign o_hit   = r_hit;

endmodule
`default_nettype wire

@@ sv/branch_label_table.sv @@
// Steps: the request is registered at the accepting edge, the look state registers
// the cell hit flags, and the update state loads the results and o_valid.
// A new request is taken in the update state of the last one, but not in the
// look state, while busy is high.
// The receiver cannot stall; each result is shown for one cycle with o_valid.
// Synchronous active-low reset empties the table (entry count to zero) and idles.
`default_nettype none
// ----------------------------------------------------------------------------
// branch_label_table
// Associative table of assembler branch labels built as a row of entry cells.
// ----------------------------------------------------------------------------
module branch_label_table
    import blt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [OCC_W-1:0]    i_occurrence,
    input  wire logic [63:0]         i_label_key,
    input  wire logic [DEPTH_W-1:0]  i_stack_depth,
    input  wire logic [BCI_W-1:0]    i_bytecode_index,
    input  wire logic [LIT_W-1:0]    i_fresh_literal,
    input  wire logic [SLOT_W-1:0]   i_vector_slot,
    output logic                     o_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [LIT_W-1:0]         o_literal_index,
    output logic                     o_literal_taken,
    output logic [BCI_W-1:0]         o_resolved_bci,
    output logic [SLOT_W-1:0]        o_slot_echo,
    output logic [DEPTH_W-1:0]       o_earlier_depth,
    output logic [BCI_W-1:0]         o_earlier_bci
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_entry_count, n_entry_count;
    logic [OP_W-1:0]    r_op;
    logic [OCC_W-1:0]   r_occ;
    logic [KEY_W-1:0]   r_key;
    logic [DEPTH_W-1:0] r_depth;
    logic [BCI_W-1:0]   r_bci;
    logic [LIT_W-1:0]   r_fresh;
    logic [SLOT_W-1:0]  r_slot;

    logic               w_accept;
    logic               w_write;
    t_cell_cmd          w_cmd;
    t_hit               w_chain [CAPACITY+1];
    logic [CAPACITY-1:0] w_hits;
    t_hit               w_h;
    logic               w_is_def;
    logic               w_is_simple;
    logic               w_full;

    logic [STATUS_W-1:0] n_status;
    logic [LIT_W-1:0]    n_lit;
    logic                n_taken;
    logic [BCI_W-1:0]    n_rbci;
    logic [DEPTH_W-1:0]  n_e_depth;
    logic [BCI_W-1:0]    n_e_bci;
    logic                n_insert;
    logic                n_set_def;
    logic                n_set_lit;
    logic                n_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                busy    = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = start ? S_LOOK : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept = start && !busy;
    assign w_write  = (r_state == S_WRITE);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_operation;
            r_occ   <= i_occurrence;
            r_key   <= i_label_key[KEY_W-1:0];
            r_depth <= i_stack_depth;
            r_bci   <= i_bytecode_index;
            r_fresh <= i_fresh_literal;
            r_slot  <= i_vector_slot;
        end
    end

    always_comb begin
        w_cmd         = '0;
        w_cmd.look    = (r_state == S_LOOK);
        w_cmd.insert  = w_write && n_insert;
        w_cmd.set_def = w_write && n_set_def;
        w_cmd.set_lit = w_write && n_set_lit;
        w_cmd.count   = r_entry_count;
        w_cmd.key     = r_key;
        w_cmd.depth   = r_depth;
        w_cmd.bci     = r_bci;
        w_cmd.defined = w_is_def;
        w_cmd.literal = r_fresh;
    end

    assign w_chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        blt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_hit   (w_hits[g])
        );
    end

    assign w_h         = w_chain[CAPACITY];
    assign w_is_def    = (r_occ == OCC_DEF);
    assign w_is_simple = (r_occ == OCC_SIMPLE);
    assign w_full      = (r_entry_count == CNT_W'(CAPACITY));

    always_comb begin
        n_status  = ST_OK;
        n_lit     = '0;
        n_taken   = 1'b0;
        n_rbci    = '0;
        n_e_depth = '0;
        n_e_bci   = '0;
        n_insert  = 1'b0;
        n_set_def = 1'b0;
        n_set_lit = 1'b0;
        n_clear   = 1'b0;
        case (r_op)
            OP_RECORD: begin
                if (!w_h.hit) begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_insert = 1'b1;
                        if (w_is_simple) begin
                            n_set_lit = 1'b1;
                            n_taken   = 1'b1;
                            n_lit     = r_fresh;
                        end
                    end
                end else begin
                    n_e_depth = w_h.depth;
                    n_e_bci   = w_h.bci;
                    if (w_h.depth != r_depth) begin
                        n_status = ST_MISMATCH;
                    end else if (w_is_def) begin
                        if (w_h.defined) begin
                            n_status = ST_MULTI_DEF;
                        end else begin
                            n_set_def = 1'b1;
                        end
                    end else if (w_is_simple) begin
                        if (!w_h.has_lit) begin
                            n_set_lit = 1'b1;
                            n_taken   = 1'b1;
                            n_lit     = r_fresh;
                        end else begin
                            n_lit = w_h.literal;
                        end
                    end
                end
            end
            OP_RESOLVE: begin
                if (w_h.hit) begin
                    n_e_depth = w_h.depth;
                    n_e_bci   = w_h.bci;
                end
                if (!w_h.hit || !w_h.defined) begin
                    n_status = ST_UNDEFINED;
                end else begin
                    n_rbci = w_h.bci;
                end
            end
            OP_CLEAR: begin
                n_clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_entry_count = r_entry_count;
        if (w_write) begin
            if (n_clear) begin
                n_entry_count = '0;
            end else if (n_insert) begin
                n_entry_count = r_entry_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            o_valid       <= 1'b0;
        end else begin
            r_entry_count <= n_entry_count;
            o_valid       <= w_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            o_status        <= n_status;
            o_literal_index <= n_lit;
            o_literal_taken <= n_taken;
            o_resolved_bci  <= n_rbci;
            o_slot_echo     <= r_slot;
            o_earlier_depth <= n_e_depth;
            o_earlier_bci   <= n_e_bci;
        end
    end

`ifndef ASSERT_OFF
    a_result_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> o_valid)
        else $error("result strobe missing after update cycle");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> $onehot0(w_hits))
        else $error("label key stored in more than one cell");

    a_error_takes_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> !o_literal_taken)
        else $error("literal taken on an error result");

    a_no_insert_when_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write && w_h.hit) |-> !w_cmd.insert)
        else $error("insert of a key already present");
`endif

endmodule
`default_nettype wire
